@@ rtl/bgd_pkg.sv @@
// Package for the Bayer gradient demosaic: default sizes, register indexes
// and the control bundle passed from the window to the kernel datapath.
// No dependencies.
package bgd_pkg;

  localparam int BGD_MAX_WIDTH  = 4096;
  localparam int BGD_PIXEL_BITS = 16;
  localparam int BGD_FIELD_W    = 16;
  localparam int BGD_CFG_W      = 13;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COL_PHASE    = 2'd2,
    REG_ROW_PHASE    = 2'd3
  } bgd_reg_t;

  typedef struct packed {
    logic last_item;
    logic last_frame;
    logic col_red;
    logic row_red;
  } bgd_ctl_t;

endpackage

@@ rtl/bgd_line_store.sv @@
// Line store of the demosaic: one entry per column holding four rows.
// Synchronous memory, one write and one registered read port. Uses nothing else.
module bgd_line_store #(
  parameter int DEPTH = 4096,
  parameter int WORD_W = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bgd_window.sv @@
// 5x5 sample window and the per-pixel job sequencer that selects the kernel
// taps with edge replication. Depends on bgd_pkg.
module bgd_window
  import bgd_pkg::*;
#(
  parameter int MAX_WIDTH = BGD_MAX_WIDTH,
  parameter int PIXEL_BITS = BGD_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift_en,
  output logic                                shift_ready,
  input  logic [4:0][PIXEL_BITS-1:0]          col_in,
  input  logic                                job_in,
  input  logic [$clog2(MAX_WIDTH)-1:0]        job_c,
  input  logic [$clog2(MAX_WIDTH)-1:0]        job_wlast,
  input  logic                                job_row_odd,
  input  logic                                job_row_end,
  input  logic                                job_frame_end,
  input  logic                                col_phase,
  input  logic                                row_phase,
  output logic                                tap_valid,
  input  logic                                tap_ready,
  output logic [12:0][PIXEL_BITS-1:0]         taps,
  output bgd_ctl_t                            tap_ctl
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SWD = CW + 3;

  logic [4:0][4:0][PIXEL_BITS-1:0] win_r;
  logic          job_valid_r;
  logic [CW-1:0] p_r;
  logic [CW-1:0] plast_r;
  logic [CW-1:0] c_r;
  logic [CW-1:0] wlast_r;
  logic          row_odd_r;
  logic          frame_r;
  logic          issue;
  logic          at_last;
  logic [2:0]    s_m2, s_m1, s_0, s_p1, s_p2;

  function automatic logic [2:0] slot_of(input logic [CW-1:0] p, input logic [CW-1:0] c,
                                         input logic [CW-1:0] wl, input int dx);
    logic signed [SWD-1:0] pc;
    logic signed [SWD-1:0] s;
    pc = $signed({3'b000, p}) + SWD'(dx);
    if (pc < 0) begin
      pc = '0;
    end
    if (pc > $signed({3'b000, wl})) begin
      pc = $signed({3'b000, wl});
    end
    s = pc - $signed({3'b000, c}) + SWD'(4);
    if (s < 0) begin
      s = '0;
    end
    if (s > SWD'(4)) begin
      s = SWD'(4);
    end
    return s[2:0];
  endfunction

  assign issue       = job_valid_r && tap_ready;
  assign at_last     = (p_r == plast_r);
  assign shift_ready = !job_valid_r || (issue && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[4] <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (shift_en && job_in) begin
      job_valid_r <= 1'b1;
    end else if (issue && at_last) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && job_in) begin
      p_r       <= job_c - CW'(2);
      plast_r   <= job_row_end ? job_wlast : job_c - CW'(2);
      c_r       <= job_c;
      wlast_r   <= job_wlast;
      row_odd_r <= job_row_odd;
      frame_r   <= job_frame_end;
    end else if (issue && !at_last) begin
      p_r <= p_r + CW'(1);
    end
  end

  always_comb begin
    s_m2 = slot_of(p_r, c_r, wlast_r, -2);
    s_m1 = slot_of(p_r, c_r, wlast_r, -1);
    s_0  = slot_of(p_r, c_r, wlast_r, 0);
    s_p1 = slot_of(p_r, c_r, wlast_r, 1);
    s_p2 = slot_of(p_r, c_r, wlast_r, 2);
    taps[0]  = win_r[s_0][2];
    taps[1]  = win_r[s_0][1];
    taps[2]  = win_r[s_0][3];
    taps[3]  = win_r[s_m1][2];
    taps[4]  = win_r[s_p1][2];
    taps[5]  = win_r[s_0][0];
    taps[6]  = win_r[s_0][4];
    taps[7]  = win_r[s_m2][2];
    taps[8]  = win_r[s_p2][2];
    taps[9]  = win_r[s_m1][1];
    taps[10] = win_r[s_p1][1];
    taps[11] = win_r[s_m1][3];
    taps[12] = win_r[s_p1][3];
    tap_ctl.last_item  = at_last;
    tap_ctl.last_frame = at_last && frame_r;
    tap_ctl.col_red    = (p_r[0] == col_phase);
    tap_ctl.row_red    = (row_odd_r == row_phase);
  end

  assign tap_valid = job_valid_r;

endmodule

@@ rtl/bgd_kernel.sv @@
// Gradient-corrected kernel datapath: tap register, kernel sums, then
// rounding and saturation into the output register. Depends on bgd_pkg.
module bgd_kernel
  import bgd_pkg::*;
#(
  parameter int PIXEL_BITS = BGD_PIXEL_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tap_valid,
  output logic                        tap_ready,
  input  logic [12:0][PIXEL_BITS-1:0] taps,
  input  bgd_ctl_t                    tap_ctl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [PIXEL_BITS-1:0]       red,
  output logic [PIXEL_BITS-1:0]       green,
  output logic [PIXEL_BITS-1:0]       blue,
  output bgd_ctl_t                    out_ctl
);

  localparam int SW = PIXEL_BITS + 8;
  localparam logic signed [SW-1:0] MAXV = SW'((1 << PIXEL_BITS) - 1);

  logic                        a_v_r, b_v_r, o_v_r;
  logic                        a_adv, b_adv, o_adv;
  logic [12:0][PIXEL_BITS-1:0] a_taps_r;
  bgd_ctl_t                    a_ctl_r, b_ctl_r, o_ctl_r;
  logic signed [SW-1:0]        b_r_r, b_g_r, b_b_r;
  logic signed [SW-1:0]        r_nxt, g_nxt, b_nxt;
  logic [PIXEL_BITS-1:0]       o_r_r, o_g_r, o_b_r;

  function automatic logic signed [SW-1:0] ext(input logic [PIXEL_BITS-1:0] x);
    return $signed(SW'(x));
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rnd_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + SW'(8);
    if (t < 0) begin
      return '0;
    end
    t = t >>> 4;
    if (t > MAXV) begin
      t = MAXV;
    end
    return t[PIXEL_BITS-1:0];
  endfunction

  assign o_adv     = !o_v_r || out_ready;
  assign b_adv     = !b_v_r || o_adv;
  assign a_adv     = !a_v_r || b_adv;
  assign tap_ready = a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= tap_valid;
      if (b_adv) b_v_r <= a_v_r;
      if (o_adv) o_v_r <= b_v_r;
    end
  end

  always_comb begin
    logic signed [SW-1:0] c, n, s, w, e, nn, ss, ww, ee, diag, cr1, cr2;
    logic signed [SW-1:0] g_rb, rb_br, horiz, vert;
    c    = ext(a_taps_r[0]);
    n    = ext(a_taps_r[1]);
    s    = ext(a_taps_r[2]);
    w    = ext(a_taps_r[3]);
    e    = ext(a_taps_r[4]);
    nn   = ext(a_taps_r[5]);
    ss   = ext(a_taps_r[6]);
    ww   = ext(a_taps_r[7]);
    ee   = ext(a_taps_r[8]);
    diag = ext(a_taps_r[9]) + ext(a_taps_r[10]) + ext(a_taps_r[11]) + ext(a_taps_r[12]);
    cr1  = n + s + w + e;
    cr2  = nn + ss + ww + ee;
    g_rb  = (c <<< 3) + (cr1 <<< 2) - (cr2 <<< 1);
    rb_br = (c <<< 3) + (c <<< 2) + (diag <<< 2) - (cr2 <<< 1) - cr2;
    horiz = (c <<< 3) + (c <<< 1) + ((w + e) <<< 3) - ((ww + ee) <<< 1)
            - (diag <<< 1) + (nn + ss);
    vert  = (c <<< 3) + (c <<< 1) + ((n + s) <<< 3) - ((nn + ss) <<< 1)
            - (diag <<< 1) + (ww + ee);
    if (a_ctl_r.col_red && a_ctl_r.row_red) begin
      r_nxt = c <<< 4; g_nxt = g_rb; b_nxt = rb_br;
    end else if (!a_ctl_r.col_red && !a_ctl_r.row_red) begin
      r_nxt = rb_br; g_nxt = g_rb; b_nxt = c <<< 4;
    end else if (a_ctl_r.row_red) begin
      r_nxt = horiz; g_nxt = c <<< 4; b_nxt = vert;
    end else begin
      r_nxt = vert; g_nxt = c <<< 4; b_nxt = horiz;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_taps_r <= taps;
      a_ctl_r  <= tap_ctl;
    end
    if (b_adv) begin
      b_r_r   <= r_nxt;
      b_g_r   <= g_nxt;
      b_b_r   <= b_nxt;
      b_ctl_r <= a_ctl_r;
    end
    if (o_adv) begin
      o_r_r   <= rnd_sat(b_r_r);
      o_g_r   <= rnd_sat(b_g_r);
      o_b_r   <= rnd_sat(b_b_r);
      o_ctl_r <= b_ctl_r;
    end
  end

  assign out_valid = o_v_r;
  assign red       = o_r_r;
  assign green     = o_g_r;
  assign blue      = o_b_r;
  assign out_ctl   = o_ctl_r;

endmodule

@@ rtl/bayer_gradient_demosaic_top.sv @@
// Streaming 5x5 gradient-corrected Bayer demosaic, one sample per cycle while in_tready is high.
// Each job yields one result; a row end yields three results and holds input back
// until the window has issued all three to the kernel, one at a time.
// Reset (rst_n low, synchronous) clears counters, window, pipeline valid flags and
// configuration registers; the line store is not cleared and needs no clearing pass.
module bayer_gradient_demosaic_top
  import bgd_pkg::*;
#(
  parameter int MAX_WIDTH = BGD_MAX_WIDTH,
  parameter int PIXEL_BITS = BGD_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] raw_sample
  input  logic                  in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [15:0] red, [31:16] green, [47:32] blue
  output logic                  out_tlast,  // last_of_item
  output logic                  out_tuser,  // [0] last_of_frame
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [BGD_CFG_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;
  localparam logic [13:0] MAXW14 = 14'(MAX_WIDTH);
  localparam logic [15:0] MAXV16 = 16'((1 << PIXEL_BITS) - 1);

  logic [12:0] width_r, height_r;
  logic        col_phase_r, row_phase_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [12:0]   row_r, row_nxt;
  logic [CW-1:0] wlast, c0;
  logic          accept, row_end0, frame_end0;
  logic [15:0]   sat16;

  logic          s1_valid_r, s1_go, win_ready;
  logic [CW-1:0] s1_c_r, s1_wlast_r;
  logic [12:0]   s1_row_r;
  logic          s1_flush_r, s1_row_end_r, s1_frame_end_r;
  logic [PB-1:0] s1_sample_r;
  logic [4*PB-1:0] rd_data, wr_data;
  logic [3:0][PB-1:0] slots, new_slots;
  logic [4:0][PB-1:0] col;
  logic [PB-1:0] cur;
  logic          job;

  logic                tap_valid, tap_ready;
  logic [12:0][PB-1:0] taps;
  bgd_ctl_t            tap_ctl, out_ctl;
  logic [PB-1:0]       red, green, blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 13'd4096;
      height_r    <= 13'd4096;
      col_phase_r <= 1'b0;
      row_phase_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (bgd_reg_t'(cfg_addr))
        REG_IMAGE_WIDTH:  width_r     <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r    <= cfg_wdata;
        REG_COL_PHASE:    col_phase_r <= cfg_wdata[0];
        REG_ROW_PHASE:    row_phase_r <= cfg_wdata[0];
        default:          width_r     <= width_r;
      endcase
    end
  end

  always_comb begin
    if ({1'b0, width_r} < 14'd4) begin
      wlast = CW'(3);
    end else if ({1'b0, width_r} > MAXW14) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(width_r - 13'd1);
    end
    c0         = (col_r > wlast) ? wlast : col_r;
    row_end0   = (c0 == wlast);
    frame_end0 = row_end0 && ({1'b0, row_r} >= ({1'b0, height_r} + 14'd1));
    sat16      = (in_tdata > MAXV16) ? MAXV16 : in_tdata;
    col_nxt    = row_end0 ? '0 : c0 + CW'(1);
    row_nxt    = row_end0 ? (frame_end0 ? 13'd0 : row_r + 13'd1) : row_r;
  end

  assign s1_go     = s1_valid_r && win_ready;
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c_r         <= c0;
      s1_wlast_r     <= wlast;
      s1_row_r       <= row_r;
      s1_flush_r     <= in_tuser;
      s1_sample_r    <= sat16[PB-1:0];
      s1_row_end_r   <= row_end0;
      s1_frame_end_r <= frame_end0;
    end
  end

  bgd_line_store #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (4 * PB)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_c_r),
    .wr_data (wr_data)
  );

  // Consecutive transfers never hit the same column, so the read-modify-write
  // of a column completes long before that column is read again.
  always_comb begin
    slots = rd_data;
    if (!s1_flush_r) begin
      cur = s1_sample_r;
    end else if (s1_row_r == 13'd0) begin
      cur = '0;
    end else begin
      cur = slots[s1_row_r[1:0] - 2'd1];
    end
    for (int i = 0; i < 4; i++) begin
      if (s1_row_r >= 13'(4 - i)) begin
        col[i] = slots[s1_row_r[1:0] + 2'(i)];
      end else if (s1_row_r == 13'd0) begin
        col[i] = cur;
      end else begin
        col[i] = slots[0];
      end
    end
    col[4]    = cur;
    new_slots = slots;
    new_slots[s1_row_r[1:0]] = cur;
    wr_data   = new_slots;
    job       = (s1_row_r >= 13'd2) && (s1_c_r >= CW'(2));
  end

  bgd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PB)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .shift_en      (s1_go),
    .shift_ready   (win_ready),
    .col_in        (col),
    .job_in        (job),
    .job_c         (s1_c_r),
    .job_wlast     (s1_wlast_r),
    .job_row_odd   (s1_row_r[0]),
    .job_row_end   (s1_row_end_r),
    .job_frame_end (s1_frame_end_r),
    .col_phase     (col_phase_r),
    .row_phase     (row_phase_r),
    .tap_valid     (tap_valid),
    .tap_ready     (tap_ready),
    .taps          (taps),
    .tap_ctl       (tap_ctl)
  );

  bgd_kernel #(
    .PIXEL_BITS (PB)
  ) u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .tap_ctl   (tap_ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_ctl   (out_ctl)
  );

  assign out_tdata = {16'(blue), 16'(green), 16'(red)};
  assign out_tlast = out_ctl.last_item;
  assign out_tuser = out_ctl.last_frame;

endmodule

@@ rtl/bgd_checker.sv @@
// Port-level checker for the demosaic top level, attached by bind.
// Depends on bgd_pkg and bayer_gradient_demosaic_top.
module bgd_port_checker
  import bgd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [47:0]          out_tdata,
  input logic                 out_tlast,
  input logic                 out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed during a stalled transfer");

  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end not on the final result of an item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_no_result_too_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |=> !out_tvalid)
    else $error("result without any input transfer");

  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tready))
    else $error("input ready unknown while an input is offered");

endmodule

bind bayer_gradient_demosaic_top bgd_port_checker u_bgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
